@@ rtl/dcs_pkg.sv @@
// dcs_pkg: shared types and fixed field widths of the difference constraint solver
// used by difference_constraint_solver_core; no dependencies
package dcs_pkg;

    // fixed field widths of the stream payloads
    localparam int VALUE_WIDTH       = 16;
    localparam int BOUND_WIDTH       = 17;
    localparam int SUM_WIDTH         = 18;
    localparam int SLOT_WIDTH        = 6;
    localparam int VAR_FIELD_WIDTH   = 5;
    localparam int INDEX_FIELD_WIDTH = 6;
    localparam int RESULT_LIMIT      = 32;
    localparam int RESULT_CNT_WIDTH  = 6;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VARIABLE_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONSTRAINT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOMAIN_SIZE      = 2'd2;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        CMD_LOAD_CONS = 2'd0,
        CMD_LOAD_DOM  = 2'd1,
        CMD_SOLVE     = 2'd2
    } t_cmd;

    // solver sequencer
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CREAD  = 10'b00_0000_0010,
        S_AREAD  = 10'b00_0000_0100,
        S_DREAD  = 10'b00_0000_1000,
        S_CMP    = 10'b00_0001_0000,
        S_DISSUE = 10'b00_0010_0000,
        S_DCHK   = 10'b00_0100_0000,
        S_OREAD  = 10'b00_1000_0000,
        S_OLOAD  = 10'b01_0000_0000,
        S_OSEND  = 10'b10_0000_0000
    } t_state;

endpackage

@@ rtl/dcs_ram.sv @@
// dcs_ram: generic synchronous ram, one write port, two registered read ports
// no dependencies
module dcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                      o_rdata_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/difference_constraint_solver_core.sv @@
// difference_constraint_solver_core: relaxation solver for x_a - x_b <= c over a domain
// depends on dcs_pkg and dcs_ram
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready      | tuser command, tdata load fields
//  m_axis    | out       | m_axis_tvalid/tready      | tuser satisfiable, tdata, tlast
//  cfg       | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// loads are written straight into the stores and may follow back to back.
// solve: per constraint per pass, constraint, assignment and domain reads, then a
// compare, plus a domain issue and check per step while a violated variable walks
// down; passes repeat until one makes no change, the last pass also decides
// satisfiability. then read, load and send per result, plus output stalls. steps
// follow the single read-modify-write path through constraint, assignment, domain rams.
// reset is synchronous; the stores hold garbage until loaded, no clearing pass.
// no request is taken while a solve or its results are in progress.
module difference_constraint_solver_core
    import dcs_pkg::*;
#(
    parameter int MAX_VARIABLES   = 32,
    parameter int MAX_CONSTRAINTS = 64,
    parameter int MAX_DOMAIN      = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command request
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [5:0] slot, [10:6] left_var, [15:11] right_var, [32:16] bound,
    // [48:33] domain_value, [55:49] zero
    input  logic [55:0]                s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                 s_axis_tuser,
    // result request
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [4:0] variable, [10:5] chosen_index, [15:11] zero
    output logic [15:0]                m_axis_tdata,
    // [0] satisfiable
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int VW     = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
    localparam int CW     = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
    localparam int CNW    = $clog2(MAX_CONSTRAINTS + 1);
    localparam int DW     = $clog2(MAX_DOMAIN);
    localparam int CONS_W = 2 * VW + BOUND_WIDTH;

    // request fields
    logic                          in_acc;
    t_cmd                          cmd;
    logic [SLOT_WIDTH-1:0]         in_slot;
    logic [VAR_FIELD_WIDTH-1:0]    in_left;
    logic [VAR_FIELD_WIDTH-1:0]    in_right;
    logic [BOUND_WIDTH-1:0]        in_bound;
    logic [VALUE_WIDTH-1:0]        in_value;

    // state
    t_state                        r_state, n_state;
    logic [RESULT_CNT_WIDTH-1:0]   r_var_cnt;
    logic [CFG_DATA_WIDTH-1:0]     r_cons_cnt;
    logic [CFG_DATA_WIDTH-1:0]     r_dom_size;
    logic [MAX_VARIABLES-1:0]      r_asg_vld, n_asg_vld;
    logic                          r_changed, n_changed;
    logic                          r_viol, n_viol;
    logic [CNW-1:0]                r_ci, n_ci;
    logic [CNW-1:0]                r_ncons, n_ncons;
    logic [DW-1:0]                 r_dom_top, n_dom_top;
    logic [RESULT_CNT_WIDTH-1:0]   r_nvar, n_nvar;
    logic [VW-1:0]                 r_a, n_a;
    logic [BOUND_WIDTH-1:0]        r_c, n_c;
    logic                          r_vld_a, n_vld_a;
    logic                          r_vld_b, n_vld_b;
    logic [DW-1:0]                 r_cur, n_cur;
    logic [DW-1:0]                 r_k, n_k;
    logic signed [SUM_WIDTH-1:0]   r_limit, n_limit;
    logic [RESULT_CNT_WIDTH-1:0]   r_oi, n_oi;
    logic                          r_out_sat, n_out_sat;
    logic [VAR_FIELD_WIDTH-1:0]    r_out_var, n_out_var;
    logic [INDEX_FIELD_WIDTH-1:0]  r_out_idx, n_out_idx;
    logic                          r_out_last, n_out_last;

    // solve-start limits
    logic [CNW-1:0]                ncons_c;
    logic [DW-1:0]                 dom_top_c;
    logic                          dom_empty_c;
    logic [RESULT_CNT_WIDTH-1:0]   nvar_c;

    // memory ports
    logic                          cons_we;
    logic [CW-1:0]                 cons_waddr;
    logic [CONS_W-1:0]             cons_wdata;
    logic [CONS_W-1:0]             cons_rd;
    logic                          dom_we;
    logic [DW-1:0]                 dom_waddr;
    logic [DW-1:0]                 dom_raddr_a;
    logic [VALUE_WIDTH-1:0]        dom_rd_a;
    logic [VALUE_WIDTH-1:0]        dom_rd_b;
    logic                          asg_we;
    logic [VW-1:0]                 asg_raddr_a;
    logic [DW-1:0]                 asg_rd_a;
    logic [DW-1:0]                 asg_rd_b;

    // datapath
    logic [VW-1:0]                 var_mod [RESULT_LIMIT];
    logic [VW-1:0]                 cons_a;
    logic [VW-1:0]                 cons_b;
    logic [BOUND_WIDTH-1:0]        cons_c;
    logic [DW-1:0]                 idx_a;
    logic [DW-1:0]                 idx_b;
    logic signed [SUM_WIDTH-1:0]   va_ext;
    logic signed [SUM_WIDTH-1:0]   vb_ext;
    logic signed [SUM_WIDTH-1:0]   c_ext;
    logic signed [SUM_WIDTH-1:0]   limit;
    logic [CNW-1:0]                ci_next;
    logic                          adv;
    logic                          adv_chg;
    logic                          adv_viol;

    // request unpacking
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign cmd      = t_cmd'(s_axis_tuser);
    assign in_slot  = s_axis_tdata[5:0];
    assign in_left  = s_axis_tdata[10:6];
    assign in_right = s_axis_tdata[15:11];
    assign in_bound = s_axis_tdata[32:16];
    assign in_value = s_axis_tdata[48:33];

    // variable numbers wrap at the store depth
    for (genvar g = 0; g < RESULT_LIMIT; g++) begin : g_var_mod
        localparam int VMOD = g % MAX_VARIABLES;
        assign var_mod[g] = VW'(VMOD);
    end

    // saturate the registers at solve start; a zero variable count becomes one
    always_comb begin
        int nc;
        int nd;
        int nv;
        nc = int'(r_cons_cnt);
        nd = int'(r_dom_size);
        nv = int'(r_var_cnt);
        if (nc > MAX_CONSTRAINTS) nc = MAX_CONSTRAINTS;
        if (nd > MAX_DOMAIN) nd = MAX_DOMAIN;
        if (nv > MAX_VARIABLES) nv = MAX_VARIABLES;
        if (nv > RESULT_LIMIT) nv = RESULT_LIMIT;
        if (nv == 0) nv = 1;
        ncons_c     = CNW'(nc);
        dom_empty_c = (nd == 0);
        dom_top_c   = DW'(nd - 1);
        nvar_c      = RESULT_CNT_WIDTH'(nv);
    end

    // loads go straight into the stores
    assign cons_we    = in_acc && (cmd == CMD_LOAD_CONS) && (int'(in_slot) < MAX_CONSTRAINTS);
    assign cons_waddr = CW'(in_slot);
    assign cons_wdata = {in_bound, var_mod[in_right], var_mod[in_left]};
    assign dom_we     = in_acc && (cmd == CMD_LOAD_DOM) && (int'(in_slot) < MAX_DOMAIN);
    assign dom_waddr  = DW'(in_slot);

    dcs_ram #(.WIDTH(CONS_W), .DEPTH(MAX_CONSTRAINTS)) u_cons_ram (
        .i_clk     (i_clk),
        .i_we      (cons_we),
        .i_waddr   (cons_waddr),
        .i_wdata   (cons_wdata),
        .i_raddr_a (r_ci[CW-1:0]),
        .o_rdata_a (cons_rd),
        .i_raddr_b (r_ci[CW-1:0]),
        .o_rdata_b ()
    );

    dcs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_DOMAIN)) u_dom_ram (
        .i_clk     (i_clk),
        .i_we      (dom_we),
        .i_waddr   (dom_waddr),
        .i_wdata   (in_value),
        .i_raddr_a (dom_raddr_a),
        .o_rdata_a (dom_rd_a),
        .i_raddr_b (idx_b),
        .o_rdata_b (dom_rd_b)
    );

    dcs_ram #(.WIDTH(DW), .DEPTH(MAX_VARIABLES)) u_asg_ram (
        .i_clk     (i_clk),
        .i_we      (asg_we),
        .i_waddr   (r_a),
        .i_wdata   (r_k),
        .i_raddr_a (asg_raddr_a),
        .o_rdata_a (asg_rd_a),
        .i_raddr_b (cons_b),
        .o_rdata_b (asg_rd_b)
    );

    // constraint fields and current indexes; unwritten assignments read as the top
    assign cons_a = cons_rd[VW-1:0];
    assign cons_b = cons_rd[2*VW-1:VW];
    assign cons_c = cons_rd[CONS_W-1:2*VW];
    assign idx_a  = r_vld_a ? asg_rd_a : r_dom_top;
    assign idx_b  = r_vld_b ? asg_rd_b : r_dom_top;

    // read address selection
    assign asg_raddr_a = (r_state == S_OREAD) ? VW'(r_oi) : cons_a;
    assign dom_raddr_a = (r_state == S_DREAD) ? idx_a : r_k;

    // exact signed compare of x_a against x_b + c
    assign va_ext  = signed'({{(SUM_WIDTH - VALUE_WIDTH){dom_rd_a[VALUE_WIDTH-1]}}, dom_rd_a});
    assign vb_ext  = signed'({{(SUM_WIDTH - VALUE_WIDTH){dom_rd_b[VALUE_WIDTH-1]}}, dom_rd_b});
    assign c_ext   = signed'({{(SUM_WIDTH - BOUND_WIDTH){r_c[BOUND_WIDTH-1]}}, r_c});
    assign limit   = vb_ext + c_ext;
    assign ci_next = r_ci + CNW'(1);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_asg_vld  = r_asg_vld;
        n_changed  = r_changed;
        n_viol     = r_viol;
        n_ci       = r_ci;
        n_ncons    = r_ncons;
        n_dom_top  = r_dom_top;
        n_nvar     = r_nvar;
        n_a        = r_a;
        n_c        = r_c;
        n_vld_a    = r_vld_a;
        n_vld_b    = r_vld_b;
        n_cur      = r_cur;
        n_k        = r_k;
        n_limit    = r_limit;
        n_oi       = r_oi;
        n_out_sat  = r_out_sat;
        n_out_var  = r_out_var;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;
        asg_we     = 1'b0;
        adv        = 1'b0;
        adv_chg    = 1'b0;
        adv_viol   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (cmd == CMD_SOLVE)) begin
                    n_ncons   = ncons_c;
                    n_dom_top = dom_top_c;
                    n_nvar    = nvar_c;
                    n_asg_vld = '0;
                    n_changed = 1'b0;
                    n_viol    = 1'b0;
                    n_ci      = '0;
                    n_oi      = '0;
                    if (dom_empty_c) begin
                        n_out_sat  = 1'b0;
                        n_out_var  = '0;
                        n_out_idx  = '0;
                        n_out_last = 1'b1;
                        n_state    = S_OSEND;
                    end else if (ncons_c == '0) begin
                        n_state = S_OREAD;
                    end else begin
                        n_state = S_CREAD;
                    end
                end
            end
            S_CREAD: begin
                n_state = S_AREAD;
            end
            // constraint word is out, fetch both assignments
            S_AREAD: begin
                n_a     = cons_a;
                n_c     = cons_c;
                n_vld_a = r_asg_vld[cons_a];
                n_vld_b = r_asg_vld[cons_b];
                n_state = S_DREAD;
            end
            // assignments are out, fetch both domain values
            S_DREAD: begin
                n_cur   = idx_a;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_limit = limit;
                if (va_ext > limit) begin
                    adv_viol = 1'b1;
                    if (r_cur != '0) begin
                        n_k     = r_cur - DW'(1);
                        n_state = S_DISSUE;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            S_DISSUE: begin
                n_state = S_DCHK;
            end
            // walk down until the value fits or index 0, then write back
            S_DCHK: begin
                if ((r_k != '0) && (va_ext > r_limit)) begin
                    n_k     = r_k - DW'(1);
                    n_state = S_DISSUE;
                end else begin
                    asg_we         = 1'b1;
                    n_asg_vld[r_a] = 1'b1;
                    adv            = 1'b1;
                    adv_chg        = 1'b1;
                end
            end
            S_OREAD: begin
                n_vld_a = r_asg_vld[VW'(r_oi)];
                n_state = S_OLOAD;
            end
            S_OLOAD: begin
                n_out_sat  = 1'b1;
                n_out_var  = r_oi[VAR_FIELD_WIDTH-1:0];
                n_out_idx  = INDEX_FIELD_WIDTH'(idx_a);
                n_out_last = ((r_oi + RESULT_CNT_WIDTH'(1)) == r_nvar);
                n_state    = S_OSEND;
            end
            S_OSEND: begin
                if (m_axis_tready) begin
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oi    = r_oi + RESULT_CNT_WIDTH'(1);
                        n_state = S_OREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next constraint, next pass or verdict
        if (adv) begin
            if (ci_next == r_ncons) begin
                n_ci = '0;
                if (r_changed || adv_chg) begin
                    n_changed = 1'b0;
                    n_viol    = 1'b0;
                    n_state   = S_CREAD;
                end else if (r_viol || adv_viol) begin
                    n_out_sat  = 1'b0;
                    n_out_var  = '0;
                    n_out_idx  = '0;
                    n_out_last = 1'b1;
                    n_state    = S_OSEND;
                end else begin
                    n_oi    = '0;
                    n_state = S_OREAD;
                end
            end else begin
                n_ci      = ci_next;
                n_changed = r_changed | adv_chg;
                n_viol    = r_viol | adv_viol;
                n_state   = S_CREAD;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_var_cnt  <= RESULT_CNT_WIDTH'(1);
            r_cons_cnt <= '0;
            r_dom_size <= CFG_DATA_WIDTH'(1);
            r_asg_vld  <= '0;
            r_changed  <= 1'b0;
            r_viol     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_asg_vld <= n_asg_vld;
            r_changed <= n_changed;
            r_viol    <= n_viol;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_VARIABLE_COUNT:   r_var_cnt  <= i_cfg_data[RESULT_CNT_WIDTH-1:0];
                    REG_CONSTRAINT_COUNT: r_cons_cnt <= i_cfg_data;
                    REG_DOMAIN_SIZE:      r_dom_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ci       <= n_ci;
        r_ncons    <= n_ncons;
        r_dom_top  <= n_dom_top;
        r_nvar     <= n_nvar;
        r_a        <= n_a;
        r_c        <= n_c;
        r_vld_a    <= n_vld_a;
        r_vld_b    <= n_vld_b;
        r_cur      <= n_cur;
        r_k        <= n_k;
        r_limit    <= n_limit;
        r_oi       <= n_oi;
        r_out_sat  <= n_out_sat;
        r_out_var  <= n_out_var;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OSEND);
    assign m_axis_tdata  = {5'd0, r_out_idx, r_out_var};
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tlast  = r_out_last;

    // no request is taken while a result is pending
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    // a solve request makes the block busy
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (cmd == CMD_SOLVE)) |=> !s_axis_tready)
        else $error("solve did not start");

    // the walk down always stays below the starting index
    a_walk_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DCHK) |-> (r_k < r_cur))
        else $error("domain walk not below current index");

    // an unsatisfiable verdict is a single zeroed last result
    a_unsat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 16'd0)))
        else $error("malformed unsatisfiable result");

    // the last result ends the solve
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after last result");

endmodule

@@ dv/difference_constraint_solver_core_tb.sv @@
// testbench for difference_constraint_solver_core: loads, solves and result checks
// depends on dcs_pkg and the solver rtl; predicts every result from its own model
`timescale 1ns / 100ps

module difference_constraint_solver_core_tb;
    import dcs_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int MAX_VARS    = 32;
    localparam int MAX_RULES   = 64;
    localparam int MAX_DOM     = 64;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_WAIT  = 20;

    // codes the block has no meaning for
    localparam logic [1:0]                 CMD_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    // one expected result
    typedef struct packed {
        logic                         satisfiable;
        logic [VAR_FIELD_WIDTH-1:0]   var_num;
        logic [INDEX_FIELD_WIDTH-1:0] chosen_index;
        logic                         last;
    } t_answer;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // [5:0] slot, [10:6] left_var, [15:11] right_var, [32:16] bound,
    // [48:33] domain_value, [55:49] zero
    logic [55:0]                s_axis_tdata = '0;
    // [1:0] command
    logic [1:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // [4:0] variable, [10:5] chosen_index, [15:11] zero
    logic [15:0]                m_axis_tdata;
    // [0] satisfiable
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data = '0;

    // mirror of the solver state
    logic signed [VALUE_WIDTH-1:0]     domain_mem [MAX_DOM];
    logic        [VAR_FIELD_WIDTH-1:0] rule_left  [MAX_RULES];
    logic        [VAR_FIELD_WIDTH-1:0] rule_right [MAX_RULES];
    logic signed [BOUND_WIDTH-1:0]     rule_bound [MAX_RULES];
    bit                                dom_written  [MAX_DOM];
    bit                                rule_written [MAX_RULES];
    logic [5:0]                        cfg_vars  = 6'd1;
    logic [6:0]                        cfg_rules = 7'd0;
    logic [6:0]                        cfg_dom   = 7'd1;

    t_answer answer_q [$];
    int      error_count    = 0;
    int      requests_sent  = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    bit      recv_hold      = 1'b0;
    int      var_span       = 31;
    int      bound_scale    = 64;

    difference_constraint_solver_core #(
        .MAX_VARIABLES   (MAX_VARS),
        .MAX_CONSTRAINTS (MAX_RULES),
        .MAX_DOMAIN      (MAX_DOM)
    ) dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .m_axis_tlast,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side readiness, random stalls or a long hold-off
    always @(negedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result: variable %0d, chosen_index %0d",
                       m_axis_tdata[4:0], m_axis_tdata[10:5]);
                error_count++;
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tuser !== want.satisfiable) begin
                    $error("satisfiable: expected %0d, got %0d", want.satisfiable, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[4:0] !== want.var_num) begin
                    $error("variable: expected %0d, got %0d", want.var_num, m_axis_tdata[4:0]);
                    error_count++;
                end
                if (m_axis_tdata[10:5] !== want.chosen_index) begin
                    $error("chosen_index: expected %0d, got %0d",
                           want.chosen_index, m_axis_tdata[10:5]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // register values as the solver uses them
    function automatic int rules_in_use();
        return (cfg_rules > MAX_RULES) ? MAX_RULES : int'(cfg_rules);
    endfunction

    function automatic int domain_in_use();
        return (cfg_dom > MAX_DOM) ? MAX_DOM : int'(cfg_dom);
    endfunction

    // relaxation: lower violating left variables until a pass changes nothing
    task automatic predict_solve();
        logic [INDEX_FIELD_WIDTH-1:0] level [MAX_VARS];
        logic signed [SUM_WIDTH-1:0]  lim;
        int                           nrules, ndom, nvar, k;
        bit                           changed, holds;
        t_answer                      ans;
        nrules = rules_in_use();
        ndom   = domain_in_use();
        nvar   = (cfg_vars > MAX_VARS) ? MAX_VARS : int'(cfg_vars);
        if (nvar == 0) nvar = 1;
        holds = (ndom != 0);
        if (holds) begin
            foreach (level[v]) level[v] = INDEX_FIELD_WIDTH'(ndom - 1);
            do begin
                changed = 1'b0;
                for (int r = 0; r < nrules; r++) begin
                    lim = domain_mem[level[rule_right[r]]] + rule_bound[r];
                    if (domain_mem[level[rule_left[r]]] > lim) begin
                        k = level[rule_left[r]];
                        while (k > 0 && domain_mem[k] > lim) k--;
                        if (k < level[rule_left[r]]) begin
                            level[rule_left[r]] = INDEX_FIELD_WIDTH'(k);
                            changed = 1'b1;
                        end
                    end
                end
            end while (changed);
            // final check over all constraints
            for (int r = 0; r < nrules; r++) begin
                lim = domain_mem[level[rule_right[r]]] + rule_bound[r];
                if (domain_mem[level[rule_left[r]]] > lim) holds = 1'b0;
            end
        end
        if (!holds) begin
            ans = '{satisfiable: 1'b0, var_num: '0, chosen_index: '0, last: 1'b1};
            answer_q.push_back(ans);
        end else begin
            for (int v = 0; v < nvar; v++) begin
                ans.satisfiable  = 1'b1;
                ans.var_num      = v[4:0];
                ans.chosen_index = level[v];
                ans.last         = (v == nvar - 1);
                answer_q.push_back(ans);
            end
        end
    endtask

    // offer one request, wait for its acceptance and update the mirror
    task automatic send_request(input logic [1:0] cmd, input logic [5:0] slot,
                                input logic [4:0] a_var, input logic [4:0] b_var,
                                input logic signed [16:0] bound,
                                input logic signed [15:0] dval);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, dval, bound, b_var, a_var, slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (cmd)
            CMD_LOAD_CONS: begin
                rule_left[slot]    = a_var;
                rule_right[slot]   = b_var;
                rule_bound[slot]   = bound;
                rule_written[slot] = 1'b1;
            end
            CMD_LOAD_DOM: begin
                domain_mem[slot]  = dval;
                dom_written[slot] = 1'b1;
            end
            CMD_SOLVE: predict_solve();
            default: ;
        endcase
        if (cmd != CMD_UNUSED) requests_sent++;
        @(negedge i_clk);
    endtask

    // drop valid and let every expected result and pending load finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // write all three registers while the block is idle
    task automatic configure(input int vars, input int rules, input int dom_size,
                             input bit poke_unused);
        wait_idle();
        i_cfg_we <= 1'b1;
        if (poke_unused) begin
            i_cfg_index <= REG_UNUSED;
            i_cfg_data  <= '1;
            @(negedge i_clk);
        end
        i_cfg_index <= REG_VARIABLE_COUNT;
        i_cfg_data  <= 7'(vars);
        @(negedge i_clk);
        i_cfg_index <= REG_CONSTRAINT_COUNT;
        i_cfg_data  <= 7'(rules);
        @(negedge i_clk);
        i_cfg_index <= REG_DOMAIN_SIZE;
        i_cfg_data  <= 7'(dom_size);
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_vars  = 6'(vars);
        cfg_rules = 7'(rules);
        cfg_dom   = 7'(dom_size);
    endtask

    task automatic load_domain(input int slot, input int value);
        send_request(CMD_LOAD_DOM, slot[5:0], 5'($urandom), 5'($urandom),
                     17'($urandom), value[15:0]);
    endtask

    task automatic load_rule(input int slot, input int a_var, input int b_var, input int c);
        send_request(CMD_LOAD_CONS, slot[5:0], a_var[4:0], b_var[4:0], c[16:0],
                     16'($urandom));
    endtask

    // occasional request with the unused command code
    task automatic maybe_send_noise();
        if ($urandom_range(0, 15) == 0)
            send_request(CMD_UNUSED, 6'($urandom), 5'($urandom), 5'($urandom),
                         17'($urandom), 16'($urandom));
    endtask

    // bounds near the spread of the domain, sometimes anything
    task automatic load_random_rule(input int slot);
        int c;
        if ($urandom_range(0, 15) == 0)
            c = int'($urandom_range(0, 131071)) - 65536;
        else
            c = int'($urandom_range(0, 3 * bound_scale)) - bound_scale;
        if (c > 65535) c = 65535;
        if (c < -65536) c = -65536;
        load_rule(slot, int'($urandom_range(0, var_span)), int'($urandom_range(0, var_span)), c);
    endtask

    // ascending domain of random spacing, now and then an unsorted one
    task automatic load_random_domain(input int count);
        int style, step, base, value;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            bound_scale = 8192;
            for (int s = 0; s < count; s++) begin
                maybe_send_noise();
                load_domain(s, int'($urandom_range(0, 65535)) - 32768);
            end
        end else begin
            step  = (style == 1) ? 65535 / count : int'($urandom_range(1, 50));
            base  = int'($urandom_range(0, 65535 - step * (count - 1))) - 32768;
            value = base;
            bound_scale = 2 * step + 1;
            for (int s = 0; s < count; s++) begin
                maybe_send_noise();
                load_domain(s, value);
                value += int'($urandom_range(0, step));
            end
        end
    endtask

    // fill store entries the solve will read but nobody loaded, then solve
    task automatic request_solve();
        int nrules, ndom;
        nrules = rules_in_use();
        ndom   = domain_in_use();
        if (nrules > 0 && ndom > 0) begin
            for (int s = 0; s < ndom; s++)
                if (!dom_written[s]) load_domain(s, int'($urandom_range(0, 65535)) - 32768);
            for (int s = 0; s < nrules; s++)
                if (!rule_written[s]) load_random_rule(s);
        end
        send_request(CMD_SOLVE, 6'($urandom), 5'($urandom), 5'($urandom),
                     17'($urandom), 16'($urandom));
    endtask

    // one system: registers, domain, constraints, solve, then a few edits and re-solves
    task automatic run_problem();
        int nvar, nrules, ndom, slot;
        nvar   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        ndom   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        nrules = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        var_span = ($urandom_range(0, 4) == 0 || nvar < 2) ? 31 : nvar - 1;
        configure(nvar, nrules, ndom, 1'b0);
        load_random_domain(ndom);
        for (int s = 0; s < nrules; s++) begin
            maybe_send_noise();
            load_random_rule(s);
        end
        request_solve();
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    load_domain(int'($urandom_range(0, ndom - 1)),
                                int'($urandom_range(0, 65535)) - 32768);
                end else begin
                    slot = (nrules > 0 && $urandom_range(0, 3) != 0) ?
                           int'($urandom_range(0, nrules - 1)) : int'($urandom_range(0, 63));
                    load_random_rule(slot);
                end
            end
            request_solve();
        end
    endtask

    // extremes of the fields and each special case
    task automatic test_directed_cases();
        // defaults after reset: one variable, no constraints
        request_solve();
        // extreme domain values and widest bounds, an impossible pair
        configure(4, 2, 4, 1'b1);
        load_domain(0, -32768);
        load_domain(1, -1);
        load_domain(2, 0);
        load_domain(3, 32767);
        load_rule(0, 31, 0, 65535);
        load_rule(1, 0, 31, -65536);
        request_solve();
        // only the first constraint in use
        configure(4, 1, 4, 1'b0);
        request_solve();
        // unused command code is ignored
        send_request(CMD_UNUSED, '1, '1, '1, '1, '1);
        // constraint on one variable against itself
        load_rule(1, 2, 2, -1);
        configure(4, 2, 4, 1'b0);
        request_solve();
        // empty domain
        configure(4, 2, 0, 1'b0);
        request_solve();
        // zero variable count reports one variable
        configure(0, 1, 4, 1'b0);
        request_solve();
        // variable count past the result limit
        configure(63, 1, 4, 1'b0);
        request_solve();
        // unsorted domain with a lowering constraint
        load_domain(1, 32767);
        load_domain(2, -32768);
        load_rule(1, 1, 0, -1);
        configure(3, 2, 4, 1'b0);
        request_solve();
    endtask

    task automatic test_random_problems(input int idle_pct, input int stall_pct,
                                        input int budget);
        int target;
        target = requests_sent + budget;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (requests_sent < target) run_problem();
    endtask

    // results held back while solves keep arriving, so the input stalls
    task automatic test_output_backpressure();
        run_problem();
        wait_idle();
        fork
            begin
                @(posedge i_clk);
                recv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                recv_hold = 1'b0;
            end
        join_none
        repeat (3) request_solve();
    endtask

    // oversized registers saturate, then the exact maxima
    task automatic test_saturated_registers();
        var_span = 31;
        configure(63, 127, 127, 1'b0);
        request_solve();
        configure(32, 64, 64, 1'b0);
        request_solve();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct  = 11;
        recv_stall_pct = 52;
        test_directed_cases();
        test_random_problems(11, 52, 25);
        test_output_backpressure();
        test_random_problems(52, 11, 25);
        test_random_problems(0, 0, 25);
        test_saturated_registers();
        wait_idle();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(200_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dcs_pkg.sv
rtl/dcs_ram.sv
rtl/difference_constraint_solver_core.sv
dv/difference_constraint_solver_core_tb.sv
